FILE: sv/can_id_rule_matcher_unit_macros.svh
// Assertion macros used by the CAN identifier rule matcher datapath.
`ifndef CAN_ID_RULE_MATCHER_UNIT_MACROS_SVH
`define CAN_ID_RULE_MATCHER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CIRM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CIRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/cirm_pkg.sv
// Types, codes and match function shared by the CAN identifier rule matcher.
package cirm_pkg;

  // Opcode of an input transfer.
  localparam logic OpAppend   = 1'b0;
  localparam logic OpClassify = 1'b1;

  // Rule match modes.
  localparam logic [1:0] ModeExact = 2'd0;
  localparam logic [1:0] ModeNode  = 2'd1;
  localparam logic [1:0] ModeFunc  = 2'd2;

  // Identifier masks used by the match modes.
  localparam logic [10:0] NodeMask  = 11'h07F;
  localparam int unsigned FuncShift = 7;
  localparam logic [3:0]  FuncMask  = 4'hF;

  // Result status codes.
  typedef enum logic [2:0] {
    StatAdded    = 3'd0,
    StatFull     = 3'd1,
    StatMatched  = 3'd2,
    StatDefault  = 3'd3,
    StatExtended = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;    // capture the input fields
    logic    append;  // write the captured rule at the end of the table
    logic    issue;   // read the next rule of the scan
    logic    emit;    // present a result for one cycle
    status_e status;  // status of the emitted result
  } cirm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_classify;  // captured opcode asks for a classification
    logic extended;     // captured frame is extended
    logic empty;        // no rules stored
    logic full;         // table holds the maximum number of rules
    logic more;         // rules remain to be read in this scan
    logic hit;          // rule checked this cycle matches the frame
    logic last_checked; // rule checked this cycle is the final stored rule
  } cirm_sts_t;

  // Returns true when a frame id matches a rule id under the given mode.
  function automatic logic rule_hits(logic [10:0] fid, logic [10:0] rid, logic [1:0] mode);
    logic res;
    case (mode)
      ModeExact: res = (fid == rid);
      ModeNode:  res = (((fid & NodeMask) & rid) == fid);
      ModeFunc:  res = ((4'(fid >> FuncShift) & FuncMask) == (4'(rid >> FuncShift) & FuncMask));
      default:   res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: sv/can_id_rule_matcher_unit.sv
// Top level of the CAN identifier rule matcher: controller and datapath.
// Takes one command when start is high and busy is low. An append command stores a rule at the
// end of the table, or reports a full table; a classify command rejects an extended frame or
// walks the stored rules in order and reports the first match or the default outcome. Every
// command gives exactly one result, shown on status_o and match_index_o for one cycle while
// done_o is high; the receiver must take it then, as it is not held. Appends, extended frames
// and classifies on an empty table are answered from the dispatch state; any other classify
// scans the stored rules, read from the rule table one rule per cycle, and stops at the first
// match or after the final stored rule.
module can_id_rule_matcher_unit
  import cirm_pkg::*;
#(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [10:0] rule_id_i,
  input  logic [1:0]  rule_mode_i,
  input  logic [10:0] frame_id_i,
  input  logic        frame_extended_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  match_index_o
);

  cirm_cmd_t cmd;
  cirm_sts_t sts;

  // Sequencing of each transfer.
  cirm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Rule table, match logic and result register.
  cirm_datapath #(
    .MAX_RULES (MAX_RULES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .rule_id_i        (rule_id_i),
    .rule_mode_i      (rule_mode_i),
    .frame_id_i       (frame_id_i),
    .frame_extended_i (frame_extended_i),
    .sts_o            (sts),
    .done_o           (done_o),
    .status_o         (status_o),
    .match_index_o    (match_index_o)
  );

endmodule

FILE: sv/cirm_ctrl.sv
// Controller state machine of the CAN identifier rule matcher.
module cirm_ctrl
  import cirm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  cirm_sts_t sts_i,
  output logic      busy,
  output cirm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle     = 3'b001,
    StDispatch = 3'b010,
    StScan     = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.status  = StatDefault;
    busy          = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StDispatch;
        end
      end
      StDispatch: begin
        if (!sts_i.is_classify) begin
          cmd_o.emit   = 1'b1;
          cmd_o.append = !sts_i.full;
          cmd_o.status = sts_i.full ? StatFull : StatAdded;
          state_d      = StIdle;
        end else if (sts_i.extended) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StatExtended;
          state_d      = StIdle;
        end else if (sts_i.empty) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StatDefault;
          state_d      = StIdle;
        end else begin
          cmd_o.issue = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (sts_i.hit) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StatMatched;
          state_d      = StIdle;
        end else if (sts_i.last_checked) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = StatDefault;
          state_d      = StIdle;
        end else begin
          cmd_o.issue = sts_i.more;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/cirm_datapath.sv
// Datapath of the CAN identifier rule matcher: rule table, scan pointer and result register.
module cirm_datapath
  import cirm_pkg::*;
#(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cirm_cmd_t   cmd_i,
  input  logic        opcode_i,
  input  logic [10:0] rule_id_i,
  input  logic [1:0]  rule_mode_i,
  input  logic [10:0] frame_id_i,
  input  logic        frame_extended_i,
  output cirm_sts_t   sts_o,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  match_index_o
);

  `include "can_id_rule_matcher_unit_macros.svh"

  localparam int unsigned IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CW = $clog2(MAX_RULES + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_RULES);

  // Rule table.
  logic [10:0] ids_mem   [MAX_RULES];
  logic [1:0]  modes_mem [MAX_RULES];

  // Captured input fields.
  logic        op_q;
  logic [10:0] rule_id_q;
  logic [1:0]  rule_mode_q;
  logic [10:0] frame_id_q;
  logic        ext_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] issue_idx_q;
  logic [IW-1:0] chk_idx_q;
  logic          chk_vld_q;
  logic [10:0]   rd_id_q;
  logic [1:0]    rd_mode_q;

  logic          done_q;
  status_e       status_q;
  logic [3:0]    index_q;

  logic          hit;

  // Capture the fields of an accepted transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= opcode_i;
      rule_id_q   <= rule_id_i;
      rule_mode_q <= rule_mode_i;
      frame_id_q  <= frame_id_i;
      ext_q       <= frame_extended_i;
    end
  end

  // Table write at the current fill level.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      ids_mem[count_q[IW-1:0]]   <= rule_id_q;
      modes_mem[count_q[IW-1:0]] <= rule_mode_q;
    end
  end

  // Registered table read for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_id_q   <= ids_mem[issue_idx_q[IW-1:0]];
      rd_mode_q <= modes_mem[issue_idx_q[IW-1:0]];
      chk_idx_q <= issue_idx_q[IW-1:0];
    end
  end

  // Fill count and scan pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      issue_idx_q <= '0;
      chk_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.load) begin
        issue_idx_q <= '0;
      end else if (cmd_i.issue) begin
        issue_idx_q <= issue_idx_q + 1'b1;
      end
      chk_vld_q <= cmd_i.issue;
    end
  end

  // Match test on the rule read in the previous cycle.
  assign hit = chk_vld_q && rule_hits(frame_id_q, rd_id_q, rd_mode_q);

  always_comb begin
    sts_o.is_classify  = (op_q == OpClassify);
    sts_o.extended     = ext_q;
    sts_o.empty        = (count_q == '0);
    sts_o.full         = (count_q == MaxCount);
    sts_o.more         = (issue_idx_q < count_q);
    sts_o.hit          = hit;
    sts_o.last_checked = chk_vld_q && ((CW'(chk_idx_q) + 1'b1) == count_q);
  end

  // Result register, shown for one cycle per transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      index_q  <= (cmd_i.status == StatMatched) ? 4'(chk_idx_q) : 4'd0;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign match_index_o = index_q;

  // The fill count never passes the table size.
  `CIRM_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= MaxCount)
  // An append with room grows the table by exactly one rule.
  `CIRM_ASSERT_NEXT(a_append_grows, clk_i, rst_ni, cmd_i.append && !sts_o.full,
                    count_q == $past(count_q) + 1'b1)
  // Only a matched result carries a nonzero index.
  `CIRM_ASSERT_SAME(a_index_zero, clk_i, rst_ni, done_q && (status_q != StatMatched),
                    index_q == 4'd0)
  // A rule under test always lies within the filled part of the table.
  `CIRM_ASSERT_SAME(a_check_in_range, clk_i, rst_ni, chk_vld_q, CW'(chk_idx_q) < count_q)

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the CAN identifier rule matcher unit.
`timescale 1ns / 100ps

module tb;
  import cirm_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned ItemCount  = 1700;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 24;
  localparam int unsigned MaxReports = 10;
  localparam logic [1:0]  ModeNever  = 2'd3;

  // One command as the driver presents it.
  typedef struct {
    logic        opcode;
    logic [10:0] rule_id;
    logic [1:0]  rule_mode;
    logic [10:0] frame_id;
    logic        frame_ext;
  } filter_cmd_t;

  // One outcome as the block reports it.
  typedef struct {
    status_e    status;
    logic [3:0] index;
  } filter_outcome_t;

  logic        clk_i            = 1'b1;
  logic        rst_ni           = 1'b0;
  logic        start            = 1'b0;
  logic        opcode_i         = OpAppend;
  logic [10:0] rule_id_i        = '0;
  logic [1:0]  rule_mode_i      = ModeExact;
  logic [10:0] frame_id_i       = '0;
  logic        frame_extended_i = 1'b0;
  logic        busy;
  logic        done_o;
  logic [2:0]  status_o;
  logic [3:0]  match_index_o;

  // Commands waiting to be driven and outcomes waiting to be seen.
  filter_cmd_t     cmd_queue[$];
  filter_outcome_t outcome_queue[$];

  // Rule table mirror used for prediction.
  logic [10:0] mirror_ids[TableDepth];
  logic [1:0]  mirror_modes[TableDepth];
  int unsigned mirror_count = 0;

  // Rule table as planned while the stimulus is built, used to aim frames at rules.
  logic [10:0] plan_ids[TableDepth];
  logic [1:0]  plan_modes[TableDepth];
  int unsigned plan_count = 0;

  logic        took_q = 1'b0;
  int unsigned sent_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  filter_cmd_t drive_cmd;

  can_id_rule_matcher_unit #(
    .MAX_RULES(TableDepth)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .rule_id_i       (rule_id_i),
    .rule_mode_i     (rule_mode_i),
    .frame_id_i      (frame_id_i),
    .frame_extended_i(frame_extended_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .match_index_o   (match_index_o)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Tells whether a frame id is accepted by one rule.
  function automatic logic id_accepted(logic [10:0] fid, logic [10:0] rid, logic [1:0] mode);
    logic ok;
    ok = 1'b0;
    case (mode)
      ModeExact: ok = (fid == rid);
      ModeNode:  ok = (fid[10:7] == 4'b0) && ((fid[6:0] & rid[6:0]) == fid[6:0]);
      ModeFunc:  ok = (fid[10:7] == rid[10:7]);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Applies one command to the mirror table and returns the outcome it should give.
  function automatic filter_outcome_t filter_outcome(filter_cmd_t cmd);
    filter_outcome_t res;
    res.status = StatDefault;
    res.index  = '0;
    if (cmd.opcode == OpAppend) begin
      if (mirror_count >= TableDepth) begin
        res.status = StatFull;
      end else begin
        mirror_ids[mirror_count]   = cmd.rule_id;
        mirror_modes[mirror_count] = cmd.rule_mode;
        mirror_count++;
        res.status = StatAdded;
      end
    end else if (cmd.frame_ext) begin
      res.status = StatExtended;
    end else begin
      for (int i = 0; i < mirror_count; i++) begin
        if (res.status == StatDefault && id_accepted(cmd.frame_id, mirror_ids[i],
                                                     mirror_modes[i])) begin
          res.status = StatMatched;
          res.index  = 4'(i);
        end
      end
    end
    return res;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Queues an append command; the frame fields carry random noise.
  task automatic queue_append(logic [10:0] rid, logic [1:0] mode);
    filter_cmd_t cmd;
    cmd.opcode    = OpAppend;
    cmd.rule_id   = rid;
    cmd.rule_mode = mode;
    cmd.frame_id  = 11'($urandom);
    cmd.frame_ext = 1'($urandom);
    cmd_queue.push_back(cmd);
    if (plan_count < TableDepth) begin
      plan_ids[plan_count]   = rid;
      plan_modes[plan_count] = mode;
      plan_count++;
    end
  endtask

  // Queues a classify command; the rule fields carry random noise.
  task automatic queue_classify(logic [10:0] fid, logic ext);
    filter_cmd_t cmd;
    cmd.opcode    = OpClassify;
    cmd.rule_id   = 11'($urandom);
    cmd.rule_mode = 2'($urandom);
    cmd.frame_id  = fid;
    cmd.frame_ext = ext;
    cmd_queue.push_back(cmd);
  endtask

  // Picks a frame id that the planned rule at the given slot accepts; for mode three it is random.
  function automatic logic [10:0] frame_aimed_at(int unsigned slot);
    logic [10:0] rid;
    logic [10:0] fid;
    rid = plan_ids[slot];
    fid = 11'($urandom);
    case (plan_modes[slot])
      ModeExact: fid = rid;
      ModeNode:  fid = {4'b0, rid[6:0] & 7'($urandom)};
      ModeFunc:  fid = {rid[10:7], 7'($urandom)};
      default:   fid = 11'($urandom);
    endcase
    return fid;
  endfunction

  // Monitor: checks each result strobe and predicts each accepted transfer.
  always @(posedge clk_i) begin
    filter_cmd_t     cmd;
    filter_outcome_t exp_res;
    if (!rst_ni) begin
      took_q <= 1'b0;
    end else begin
      took_q <= start && !busy;
      if (done_o) begin
        if (outcome_queue.size() == 0) begin
          note_failure($sformatf("result with nothing pending: status %0d index %0d",
                                 status_o, match_index_o));
        end else begin
          exp_res = outcome_queue.pop_front();
          if (status_o !== exp_res.status) begin
            note_failure($sformatf("status mismatch: expected %0d, actual %0d",
                                   exp_res.status, status_o));
          end
          if (match_index_o !== exp_res.index) begin
            note_failure($sformatf("match_index mismatch: expected %0d, actual %0d",
                                   exp_res.index, match_index_o));
          end
        end
      end
      if (start && !busy) begin
        cmd.opcode    = opcode_i;
        cmd.rule_id   = rule_id_i;
        cmd.rule_mode = rule_mode_i;
        cmd.frame_id  = frame_id_i;
        cmd.frame_ext = frame_extended_i;
        outcome_queue.push_back(filter_outcome(cmd));
        sent_count++;
      end
    end
  end

  // Driver: holds a command until its transfer, then loads the next one or idles.
  always @(negedge clk_i) begin
    logic idle_ok;
    if (rst_ni && (!start || took_q)) begin
      idle_ok = !(sent_count >= 700 && sent_count < 1000);
      if (cmd_queue.size() > 0 && !(idle_ok && $urandom_range(0, 99) < 33)) begin
        drive_cmd = cmd_queue.pop_front();
        start            <= 1'b1;
        opcode_i         <= drive_cmd.opcode;
        rule_id_i        <= drive_cmd.rule_id;
        rule_mode_i      <= drive_cmd.rule_mode;
        frame_id_i       <= drive_cmd.frame_id;
        frame_extended_i <= drive_cmd.frame_ext;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned pick;
    int unsigned directed_count;
    logic [10:0] rid;
    logic [10:0] fid;

    // Directed part: empty table, each mode, mode three, extremes of the ids.
    queue_classify(11'h000, 1'b0);
    queue_classify(11'h7FF, 1'b1);
    queue_append(11'h7FF, ModeExact);
    queue_append(11'h05A, ModeNode);
    queue_append(11'h400, ModeFunc);
    queue_append(11'h123, ModeNever);
    queue_append(11'h000, ModeExact);
    queue_classify(11'h7FF, 1'b0);
    queue_classify(11'h7FF, 1'b1);
    queue_classify(11'h000, 1'b1);
    queue_classify(11'h05A, 1'b0);
    queue_classify(11'h012, 1'b0);
    queue_classify(11'h0DA, 1'b0);
    queue_classify(11'h080, 1'b0);
    queue_classify(11'h45F, 1'b0);
    queue_classify(11'h7FE, 1'b0);
    queue_classify(11'h123, 1'b0);
    queue_classify(11'h000, 1'b0);
    queue_classify(11'h07F, 1'b0);
    directed_count = cmd_queue.size();

    // Random part: the table fills early, so later appends find it full.
    for (int n = directed_count; n < ItemCount; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        rid = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 127)) : 11'($urandom);
        queue_append(rid, 2'($urandom_range(0, 3)));
      end else if (pick < 16) begin
        queue_classify(11'($urandom), 1'b1);
      end else if (pick < 70) begin
        queue_classify(frame_aimed_at($urandom_range(0, plan_count - 1)), 1'b0);
      end else begin
        case ($urandom_range(0, 5))
          0:       fid = 11'h000;
          1:       fid = 11'h7FF;
          2:       fid = 11'($urandom_range(0, 127));
          default: fid = 11'($urandom);
        endcase
        queue_classify(fid, 1'b0);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transfer and every result, then let the block settle.
    while (cmd_queue.size() > 0 || start || outcome_queue.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
